>>> rtl/core/snapped_axis_vector_rotation_assert.svh
// Assertion macros for the snapped axis vector rotation block.
// Used inside modules that declare clk and rst_n; no other dependencies.
`ifndef SNAPPED_AXIS_VECTOR_ROTATION_ASSERT_SVH
`define SNAPPED_AXIS_VECTOR_ROTATION_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SAVR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SAVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/savr_pkg.sv
// Shared types, constants and the quarter-wave sine table for the
// snapped axis vector rotation block. No dependencies.
package savr_pkg;

  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 16;
  localparam int THR_W    = 13;
  localparam int THR_RST  = 182;
  localparam int SC_W     = 16;
  localparam int SINE_W   = 15;
  localparam int STEP_W   = 9;
  localparam int TBL_BITS = 6;
  localparam int TBL_N    = 1 << TBL_BITS;
  localparam int QR_W     = ANGLE_W - 2;
  localparam int FRAC_W   = QR_W - TBL_BITS;
  localparam int PROD_W   = COORD_W + SC_W;
  localparam int ONE_Q14  = 16384;
  localparam int SHIFT_Q  = 14;

  localparam logic signed [SC_W-1:0] SC_ONE  = SC_W'(ONE_Q14);
  localparam logic signed [SC_W-1:0] SC_ZERO = '0;

  localparam logic [SINE_W-1:0] QUARTER_SINE [0:TBL_N-1] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
    15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
    15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
    15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
    15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
    15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
    15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
    15'd16379
  };

  typedef enum logic [1:0] {
    OP_X    = 2'd0,
    OP_Y    = 2'd1,
    OP_Z    = 2'd2,
    OP_NONE = 2'd3
  } savr_op_t;

  typedef struct packed {
    savr_op_t                   op;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [COORD_W-1:0]  x_in;
    logic signed [COORD_W-1:0]  y_in;
    logic signed [COORD_W-1:0]  z_in;
  } savr_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x_out;
    logic signed [COORD_W-1:0]  y_out;
    logic signed [COORD_W-1:0]  z_out;
    logic                       was_snapped;
  } savr_out_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } savr_adv_t;

  function automatic logic [SINE_W-1:0] sine_entry(input logic [TBL_BITS:0] idx);
    logic [SINE_W-1:0] val;
    if (idx[TBL_BITS]) begin
      val = SINE_W'(ONE_Q14);
    end else begin
      val = QUARTER_SINE[idx[TBL_BITS-1:0]];
    end
    return val;
  endfunction

endpackage

>>> rtl/core/snapped_axis_vector_rotation.sv
// Rotates one Q16.16 point per cycle while in_stall is low, about the x, y or
// z axis by a binary angle; angles within the configured threshold of a
// multiple of a right angle use exact sine and cosine. Four register stages:
// angle split and table fetch, interpolation, the four COORD_W x 16 products,
// then rounding and saturation into the output register, which drives
// out_valid. A stage frees as soon as the next one can take its item, so
// in_stall rises only when all four stages hold items and out_stall is high.
// Depends on savr_pkg, savr_trig, savr_rotate.
module snapped_axis_vector_rotation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  savr_pkg::savr_in_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output savr_pkg::savr_out_t             out_item,
  input  logic                            cfg_wr_en,
  input  logic [savr_pkg::THR_W-1:0]      cfg_wr_data
);
  import savr_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             v1_r, v2_r, v3_r, v4_r;
  savr_adv_t        adv;
  savr_in_t         item1_r, item2_r, item3_r, item4_r;
  logic             snap3_r, snap4_r;

  logic signed [SC_W-1:0]    sin_w, cos_w;
  logic                      snap_w;
  logic signed [COORD_W-1:0] u, v;
  logic signed [COORD_W-1:0] a_w, b_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(THR_RST);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    adv.s4   = !v4_r || !out_stall;
    adv.s3   = !v3_r || adv.s4;
    adv.s2   = !v2_r || adv.s3;
    adv.s1   = !v1_r || adv.s2;
    in_stall = !adv.s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_valid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
      if (adv.s4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) item1_r <= in_item;
    if (adv.s2) item2_r <= item1_r;
    if (adv.s3) begin
      item3_r <= item2_r;
      snap3_r <= snap_w;
    end
    if (adv.s4) begin
      item4_r <= item3_r;
      snap4_r <= snap3_r;
    end
  end

  savr_trig u_trig (
    .clk       (clk),
    .adv       (adv),
    .angle     (in_item.angle),
    .thr       (thr_r),
    .sin_o     (sin_w),
    .cos_o     (cos_w),
    .snapped_o (snap_w)
  );

  // pick the coordinate pair that turns
  always_comb begin
    unique case (item2_r.op)
      OP_Y: begin u = item2_r.z_in; v = item2_r.x_in; end
      OP_Z: begin u = item2_r.x_in; v = item2_r.y_in; end
      default: begin u = item2_r.y_in; v = item2_r.z_in; end
    endcase
  end

  savr_rotate u_rotate (
    .clk   (clk),
    .adv   (adv),
    .u     (u),
    .v     (v),
    .sin_i (sin_w),
    .cos_i (cos_w),
    .a_o   (a_w),
    .b_o   (b_w)
  );

  // route the rotated pair back to its axes
  always_comb begin
    out_item.x_out       = item4_r.x_in;
    out_item.y_out       = item4_r.y_in;
    out_item.z_out       = item4_r.z_in;
    out_item.was_snapped = snap4_r && (item4_r.op != OP_NONE);
    unique case (item4_r.op)
      OP_X: begin
        out_item.y_out = a_w;
        out_item.z_out = b_w;
      end
      OP_Y: begin
        out_item.z_out = a_w;
        out_item.x_out = b_w;
      end
      OP_Z: begin
        out_item.x_out = a_w;
        out_item.y_out = b_w;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = v4_r;

  `include "snapped_axis_vector_rotation_assert.svh"

  `SAVR_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && v3_r && v4_r && out_stall)
  `SAVR_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v1_r)
  `SAVR_ASSERT_NOW(a_none_unsnapped, out_valid && item4_r.op == OP_NONE, !out_item.was_snapped)

endmodule

>>> rtl/core/savr_trig.sv
// Sine and cosine generation: quadrant split, snap decision, table lookup
// and interpolation over two register stages. Depends on savr_pkg.
module savr_trig (
  input  logic                                 clk,
  input  savr_pkg::savr_adv_t                  adv,
  input  logic signed [savr_pkg::ANGLE_W-1:0]  angle,
  input  logic [savr_pkg::THR_W-1:0]           thr,
  output logic signed [savr_pkg::SC_W-1:0]     sin_o,
  output logic signed [savr_pkg::SC_W-1:0]     cos_o,
  output logic                                 snapped_o
);
  import savr_pkg::*;

  localparam int IP_W = STEP_W + FRAC_W + 1;
  localparam logic [QR_W:0]   QUARTER = (QR_W+1)'(1) << QR_W;
  localparam logic [IP_W-1:0] IP_HALF = IP_W'(1) << (FRAC_W - 1);

  logic [1:0]        quad;
  logic [QR_W-1:0]   r;
  logic [QR_W:0]     hr;
  logic [QR_W:0]     snap_dist;
  logic [TBL_BITS:0] lo_idx;
  logic [TBL_BITS:0] hi_idx;
  logic [SINE_W-1:0] lo_base_nxt, hi_base_nxt;
  logic [SINE_W-1:0] lo_diff, hi_diff;

  logic [1:0]        quad_r;
  logic              snap_r;
  logic [1:0]        snap_n_r;
  logic [SINE_W-1:0] lo_base_r, hi_base_r;
  logic [STEP_W-1:0] lo_step_r, hi_step_r;
  logic [FRAC_W-1:0] lo_frac_r, hi_frac_r;

  logic [IP_W-1:0]         lo_ip, hi_ip;
  logic [SINE_W-1:0]       lo_v, hi_v;
  logic signed [SC_W-1:0]  lo_s, hi_s;
  logic signed [SC_W-1:0]  sin_nxt, cos_nxt;
  logic signed [SC_W-1:0]  sin_r, cos_r;
  logic                    snapped_r;

  // stage 1: split angle, decide snap, fetch table entries
  always_comb begin
    quad        = angle[ANGLE_W-1:ANGLE_W-2];
    r           = angle[QR_W-1:0];
    hr          = QUARTER - {1'b0, r};
    snap_dist   = r[QR_W-1] ? hr : {1'b0, r};
    lo_idx      = {1'b0, r[QR_W-1:FRAC_W]};
    hi_idx      = hr[QR_W:FRAC_W];
    lo_base_nxt = sine_entry(lo_idx);
    hi_base_nxt = sine_entry(hi_idx);
    lo_diff     = sine_entry(lo_idx + (TBL_BITS+1)'(1)) - lo_base_nxt;
    hi_diff     = sine_entry(hi_idx + (TBL_BITS+1)'(1)) - hi_base_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      quad_r    <= quad;
      snap_r    <= 32'(snap_dist) <= 32'(thr);
      snap_n_r  <= quad + {1'b0, r[QR_W-1]};
      lo_base_r <= lo_base_nxt;
      hi_base_r <= hi_base_nxt;
      lo_step_r <= lo_diff[STEP_W-1:0];
      hi_step_r <= hi_diff[STEP_W-1:0];
      lo_frac_r <= r[FRAC_W-1:0];
      hi_frac_r <= hr[FRAC_W-1:0];
    end
  end

  // stage 2: interpolate and map to the quadrant
  always_comb begin
    lo_ip = IP_W'(lo_step_r) * IP_W'(lo_frac_r) + IP_HALF;
    hi_ip = IP_W'(hi_step_r) * IP_W'(hi_frac_r) + IP_HALF;
    lo_v  = lo_base_r + SINE_W'(lo_ip[IP_W-1:FRAC_W]);
    hi_v  = hi_base_r + SINE_W'(hi_ip[IP_W-1:FRAC_W]);
    lo_s  = {1'b0, lo_v};
    hi_s  = {1'b0, hi_v};
    if (snap_r) begin
      unique case (snap_n_r)
        2'd0: begin sin_nxt = SC_ZERO; cos_nxt = SC_ONE;  end
        2'd1: begin sin_nxt = SC_ONE;  cos_nxt = SC_ZERO; end
        2'd2: begin sin_nxt = SC_ZERO; cos_nxt = -SC_ONE; end
        default: begin sin_nxt = -SC_ONE; cos_nxt = SC_ZERO; end
      endcase
    end else begin
      unique case (quad_r)
        2'd0: begin sin_nxt = lo_s;  cos_nxt = hi_s;  end
        2'd1: begin sin_nxt = hi_s;  cos_nxt = -lo_s; end
        2'd2: begin sin_nxt = -lo_s; cos_nxt = -hi_s; end
        default: begin sin_nxt = -hi_s; cos_nxt = lo_s; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sin_r     <= sin_nxt;
      cos_r     <= cos_nxt;
      snapped_r <= snap_r;
    end
  end

  assign sin_o     = sin_r;
  assign cos_o     = cos_r;
  assign snapped_o = snapped_r;

endmodule

>>> rtl/core/savr_rotate.sv
// Plane rotation of one coordinate pair: four products in one stage, then
// sums, rounding and saturation in the next. Depends on savr_pkg.
module savr_rotate (
  input  logic                                 clk,
  input  savr_pkg::savr_adv_t                  adv,
  input  logic signed [savr_pkg::COORD_W-1:0]  u,
  input  logic signed [savr_pkg::COORD_W-1:0]  v,
  input  logic signed [savr_pkg::SC_W-1:0]     sin_i,
  input  logic signed [savr_pkg::SC_W-1:0]     cos_i,
  output logic signed [savr_pkg::COORD_W-1:0]  a_o,
  output logic signed [savr_pkg::COORD_W-1:0]  b_o
);
  import savr_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam int Q_W   = SUM_W - SHIFT_Q;
  localparam logic signed [SUM_W-1:0]   RND   = SUM_W'(ONE_Q14 / 2);
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SUM_W-1:0] t;
    logic signed [Q_W-1:0]   q;
    logic [Q_W-COORD_W:0]    hi;
    logic signed [COORD_W-1:0] res;
    t  = s + RND;
    q  = t[SUM_W-1:SHIFT_Q];
    hi = q[Q_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      res = q[COORD_W-1:0];
    end else if (q[Q_W-1]) begin
      res = C_MIN;
    end else begin
      res = C_MAX;
    end
    return res;
  endfunction

  logic signed [PROD_W-1:0]  uc_r, vs_r, us_r, vc_r;
  logic signed [SUM_W-1:0]   sum_a, sum_b;
  logic signed [COORD_W-1:0] a_r, b_r;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      uc_r <= PROD_W'(u) * PROD_W'(cos_i);
      vs_r <= PROD_W'(v) * PROD_W'(sin_i);
      us_r <= PROD_W'(u) * PROD_W'(sin_i);
      vc_r <= PROD_W'(v) * PROD_W'(cos_i);
    end
  end

  always_comb begin
    sum_a = SUM_W'(uc_r) - SUM_W'(vs_r);
    sum_b = SUM_W'(us_r) + SUM_W'(vc_r);
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      a_r <= round_sat(sum_a);
      b_r <= round_sat(sum_b);
    end
  end

  assign a_o = a_r;
  assign b_o = b_r;

endmodule
